>>> hdl/msie_pkg.sv
package msie_pkg;

   localparam int MSIE_MEM_BYTES = 65536;
   localparam int MSIE_NUM_REGS  = 32;
   localparam int MSIE_REG_BITS  = 5;
   localparam int MSIE_LINK_REG  = 31;
   localparam int MSIE_OP_MAX    = 18;

   localparam int RSP_DATA_BITS  = 88;

   // opcodes
   localparam logic [5:0] OP_HALT = 6'd0;
   localparam logic [5:0] OP_ADD  = 6'd1;
   localparam logic [5:0] OP_ADDI = 6'd2;
   localparam logic [5:0] OP_SUB  = 6'd3;
   localparam logic [5:0] OP_SUBI = 6'd4;
   localparam logic [5:0] OP_MUL  = 6'd5;
   localparam logic [5:0] OP_MULI = 6'd6;
   localparam logic [5:0] OP_LB   = 6'd7;
   localparam logic [5:0] OP_SB   = 6'd8;
   localparam logic [5:0] OP_BEQ  = 6'd9;
   localparam logic [5:0] OP_BNE  = 6'd10;
   localparam logic [5:0] OP_BLT  = 6'd11;
   localparam logic [5:0] OP_BGT  = 6'd12;
   localparam logic [5:0] OP_BLE  = 6'd13;
   localparam logic [5:0] OP_BGE  = 6'd14;
   localparam logic [5:0] OP_J    = 6'd15;
   localparam logic [5:0] OP_JR   = 6'd16;
   localparam logic [5:0] OP_JAL  = 6'd17;
   localparam logic [5:0] OP_OUT  = 6'd18;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_F0,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4,
      ST_RA,
      ST_RB,
      ST_RC,
      ST_EXEC,
      ST_LB,
      ST_DRD,
      ST_DWR
   } state_type;

   typedef struct packed {
      logic        reg_we;
      logic [31:0] reg_wdata;
      logic        mem_we;
      logic [7:0]  mem_wdata;
      logic [31:0] mem_addr;
      logic [31:0] pc_next;
      logic        halt;
      logic        is_lb;
      logic        bad;
      logic        chv;
      logic [7:0]  ch;
   } alu_out_type;

endpackage

>>> hdl/mips_subset_instruction_executor_core.sv
// small 32-bit load/store core with a byte-wide program memory
//
// req channel: one word per item; req_tuser is the kind (0 = write a
// program byte, 1 = execute one instruction), req_tdata carries the
// byte address and the byte value
// rsp channel: one word per item, except an executed halt, which gives
// 32 register dump words, register 0 first, with rsp_tlast on the final one
//
// order: a byte write answers in the cycle after it is taken; a step
// answers after four fetch reads from the byte memory, three register
// file reads and execute, a byte load after one more data memory read;
// a halt then streams its dump, each word a register file read, then
// output. the single read port of each memory sets this order; one item
// is worked on at a time
// reset: a clearing pass writes zero through the whole byte memory and the
// register file, while req_tready stays low
// stall: results sit in an output register; while it is full and not
// taken, the core holds its finished result and accepts no new word
module mips_subset_instruction_executor_core
   import msie_pkg::*;
#(
   parameter int MEM_BYTES = MSIE_MEM_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // load_address [15:0], load_byte [23:16]
   input  logic [23:0]              req_tdata,
   // kind
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pc_value [31:0], halted [32], char_valid [33], char_value [41:34],
   // bad_opcode [42], dump_valid [43], dump_index [48:44], dump_value [80:49]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);

   localparam int AW = $clog2(MEM_BYTES);

   state_type state_ff, state_in;

   logic [31:0]              pc_ff, pc_in;
   logic                     halt_ff, halt_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic [7:0]               b0_ff, b1_ff, b2_ff;
   logic [31:0]              word_ff;
   logic [31:0]              word_now;
   logic [31:0]              a_ff, b_ff, c_ff;
   logic [MSIE_REG_BITS-1:0] dump_idx_ff, dump_idx_in;

   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                     rsp_tlast_ff, rsp_tlast_in;

   // memory ports
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr, mem_raddr;
   logic [7:0]               mem_wdata, mem_rdata;
   logic                     reg_we;
   logic [MSIE_REG_BITS-1:0] reg_waddr, reg_raddr;
   logic [31:0]              reg_wdata, reg_rdata;

   alu_out_type              alu;

   logic                     out_free;
   logic                     req_fire;
   logic                     emit;
   logic [7:0]               emit_ch;
   logic                     emit_chv;
   logic                     emit_bad;
   logic                     emit_dump;
   logic                     emit_last;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign word_now   = {mem_rdata, b2_ff, b1_ff, b0_ff};

   msie_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_byte_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   msie_ram #(
      .WIDTH (32),
      .DEPTH (MSIE_NUM_REGS)
   ) u_reg_file (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (reg_waddr),
      .wr_data (reg_wdata),
      .rd_addr (reg_raddr),
      .rd_data (reg_rdata)
   );

   msie_alu u_alu (
      .word (word_ff),
      .here (pc_ff),
      .a    (a_ff),
      .b    (b_ff),
      .c    (c_ff),
      .res  (alu)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(MEM_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && req_tuser == KIND_STEP && !halt_ff) begin
               state_in = ST_F0;
            end
         end
         ST_F0: state_in = ST_F1;
         ST_F1: state_in = ST_F2;
         ST_F2: state_in = ST_F3;
         ST_F3: state_in = ST_F4;
         ST_F4: state_in = ST_RA;
         ST_RA: state_in = ST_RB;
         ST_RB: state_in = ST_RC;
         ST_RC: state_in = ST_EXEC;
         ST_EXEC: begin
            if (alu.halt) begin
               state_in = ST_DRD;
            end else if (alu.is_lb) begin
               state_in = ST_LB;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LB: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DRD: state_in = ST_DWR;
         ST_DWR: begin
            if (out_free) begin
               state_in = (dump_idx_ff == MSIE_REG_BITS'(MSIE_NUM_REGS - 1)) ?
                          ST_IDLE : ST_DRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      pc_in       = pc_ff;
      halt_in     = halt_ff;
      clr_addr_in = clr_addr_ff + AW'(1);
      dump_idx_in = dump_idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = alu.mem_addr[AW-1:0];
      mem_wdata   = alu.mem_wdata;
      mem_raddr   = pc_ff[AW-1:0];
      reg_we      = 1'b0;
      reg_waddr   = word_ff[25:21];
      reg_wdata   = alu.reg_wdata;
      reg_raddr   = dump_idx_ff;
      emit        = 1'b0;
      emit_chv    = 1'b0;
      emit_ch     = 8'd0;
      emit_bad    = 1'b0;
      emit_dump   = 1'b0;
      emit_last   = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = 8'd0;
            reg_we    = 1'b1;
            reg_waddr = clr_addr_ff[MSIE_REG_BITS-1:0];
            reg_wdata = 32'd0;
         end
         ST_IDLE: begin
            if (req_fire) begin
               emit = 1'b1;
               if (req_tuser == KIND_LOAD) begin
                  mem_we    = 1'b1;
                  mem_waddr = req_tdata[AW-1:0];
                  mem_wdata = req_tdata[23:16];
               end else if (!halt_ff) begin
                  emit = 1'b0;
               end
            end
         end
         ST_F0: mem_raddr = pc_ff[AW-1:0];
         ST_F1: mem_raddr = pc_ff[AW-1:0] + AW'(1);
         ST_F2: mem_raddr = pc_ff[AW-1:0] + AW'(2);
         ST_F3: mem_raddr = pc_ff[AW-1:0] + AW'(3);
         ST_F4: reg_raddr = word_now[25:21];
         ST_RA: reg_raddr = word_ff[20:16];
         ST_RB: reg_raddr = word_ff[15:11];
         ST_EXEC: begin
            mem_raddr = alu.mem_addr[AW-1:0];
            if (alu.halt) begin
               halt_in     = 1'b1;
               pc_in       = alu.pc_next;
               dump_idx_in = '0;
            end else if (!alu.is_lb && out_free) begin
               emit     = 1'b1;
               emit_chv = alu.chv;
               emit_ch  = alu.ch;
               emit_bad = alu.bad;
               pc_in    = alu.pc_next;
               mem_we   = alu.mem_we;
               reg_we   = alu.reg_we;
               if (word_ff[31:26] == OP_JAL) begin
                  reg_waddr = MSIE_REG_BITS'(MSIE_LINK_REG);
               end
            end
         end
         ST_LB: begin
            mem_raddr = alu.mem_addr[AW-1:0];
            if (out_free) begin
               emit      = 1'b1;
               pc_in     = alu.pc_next;
               reg_we    = 1'b1;
               reg_wdata = {24'd0, mem_rdata};
            end
         end
         ST_DWR: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_dump   = 1'b1;
               emit_last   = (dump_idx_ff == MSIE_REG_BITS'(MSIE_NUM_REGS - 1));
               dump_idx_in = dump_idx_ff + MSIE_REG_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tlast_in  = emit_last;
         rsp_tdata_in  = '0;
         rsp_tdata_in[31:0]  = pc_in;
         rsp_tdata_in[32]    = halt_in;
         rsp_tdata_in[33]    = emit_chv;
         rsp_tdata_in[41:34] = emit_ch;
         rsp_tdata_in[42]    = emit_bad;
         rsp_tdata_in[43]    = emit_dump;
         if (emit_dump) begin
            rsp_tdata_in[48:44] = dump_idx_ff;
            rsp_tdata_in[80:49] = reg_rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pc_ff         <= '0;
         halt_ff       <= 1'b0;
         clr_addr_ff   <= '0;
         dump_idx_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         halt_ff       <= halt_in;
         clr_addr_ff   <= clr_addr_in;
         dump_idx_ff   <= dump_idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      case (state_ff)
         ST_F1: b0_ff <= mem_rdata;
         ST_F2: b1_ff <= mem_rdata;
         ST_F3: b2_ff <= mem_rdata;
         ST_F4: word_ff <= word_now;
         ST_RA: a_ff <= reg_rdata;
         ST_RB: b_ff <= reg_rdata;
         ST_RC: c_ff <= reg_rdata;
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

>>> hdl/msie_ram.sv
module msie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/msie_alu.sv
module msie_alu
   import msie_pkg::*;
(
   input  logic [31:0]  word,
   input  logic [31:0]  here,
   input  logic [31:0]  a,
   input  logic [31:0]  b,
   input  logic [31:0]  c,
   output alu_out_type  res
);

   logic [5:0]  op;
   logic [31:0] imm;
   logic [31:0] seq_pc;
   logic [31:0] br_pc;
   logic [31:0] jmp_pc;
   logic        take;
   logic [31:0] prod_src;

   assign op       = word[31:26];
   assign imm      = {{16{word[15]}}, word[15:0]};
   assign seq_pc   = here + 32'd4;
   assign br_pc    = here + {imm[29:0], 2'b00};
   assign jmp_pc   = {16'd0, word[15:0]};
   assign prod_src = (op == OP_MUL) ? c : imm;

   always_comb begin
      res           = '0;
      res.pc_next   = seq_pc;
      res.mem_addr  = b + imm;
      res.mem_wdata = a[7:0];
      take          = 1'b0;
      case (op)
         OP_HALT: res.halt = 1'b1;
         OP_ADD: begin
            res.reg_we    = 1'b1;
            res.reg_wdata = b + c;
         end
         OP_ADDI: begin
            res.reg_we    = 1'b1;
            res.reg_wdata = b + imm;
         end
         OP_SUB: begin
            res.reg_we    = 1'b1;
            res.reg_wdata = b - c;
         end
         OP_SUBI: begin
            res.reg_we    = 1'b1;
            res.reg_wdata = b - imm;
         end
         OP_MUL, OP_MULI: begin
            res.reg_we    = 1'b1;
            res.reg_wdata = b * prod_src;
         end
         OP_LB:  res.is_lb  = 1'b1;
         OP_SB:  res.mem_we = 1'b1;
         OP_BEQ: take = (a == b);
         OP_BNE: take = (a != b);
         OP_BLT: take = ($signed(a) < $signed(b));
         OP_BGT: take = ($signed(b) < $signed(a));
         OP_BLE: take = !($signed(b) < $signed(a));
         OP_BGE: take = !($signed(a) < $signed(b));
         OP_J:   res.pc_next = jmp_pc;
         OP_JR:  res.pc_next = a;
         OP_JAL: begin
            res.reg_we    = 1'b1;
            res.reg_wdata = seq_pc;
            res.pc_next   = jmp_pc;
         end
         OP_OUT: begin
            res.chv = 1'b1;
            res.ch  = a[7:0];
         end
         default: res.bad = 1'b1;
      endcase
      if (take) begin
         res.pc_next = br_pc;
      end
   end

endmodule

>>> hdl/msie_checker.sv
module msie_checker
   import msie_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   // held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   // no new request is taken while a result waits
   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request taken while rsp word waits");

   // a dump word ends the run exactly at the top register
   a_dump_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[43] |-> (rsp_tlast == (rsp_tdata[48:44] == 5'd31)))
      else $error("dump last flag misplaced");

   // a dump word always reports the halted core
   a_dump_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[43] |-> rsp_tdata[32])
      else $error("dump word without halt flag");

   // nothing is taken in the cycle after reset, the clearing pass runs
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input taken during clearing pass");

endmodule

bind mips_subset_instruction_executor_core msie_checker u_msie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/sv/mips_subset_instruction_executor_core_test.sv
`timescale 1ns / 100ps

module mips_subset_instruction_executor_core_test
   import msie_pkg::*;
;

   // one expected response word, fields as they appear on rsp_tdata
   typedef struct {
      logic [31:0] pc_value;
      logic        halted;
      logic        char_valid;
      logic [7:0]  char_value;
      logic        bad_opcode;
      logic        dump_valid;
      logic [4:0]  dump_index;
      logic [31:0] dump_value;
      logic        last;
   } core_result_type;

   // shadow copy of the core plus the queue of responses it predicts
   class core_scoreboard;
      bit [31:0]       pc;
      bit              halted;
      bit [31:0]       regs [MSIE_NUM_REGS];
      bit [7:0]        mem [MSIE_MEM_BYTES];
      core_result_type expected_words [$];
      int              errors;

      function void push_word(bit chv, bit [7:0] ch, bit bad, bit dv, bit [4:0] di,
                              bit [31:0] dval, bit last);
         core_result_type r;
         r.pc_value   = pc;
         r.halted     = halted;
         r.char_valid = chv;
         r.char_value = ch;
         r.bad_opcode = bad;
         r.dump_valid = dv;
         r.dump_index = di;
         r.dump_value = dval;
         r.last       = last;
         expected_words.push_back(r);
      endfunction

      // runs one accepted request word through the shadow core
      function void note_request(bit kind, bit [15:0] addr, bit [7:0] value);
         bit [31:0] word, here, a, b, c, imm;
         bit [5:0]  op;
         bit [4:0]  r1, r2, r3;
         bit        take, chv, bad;
         bit [7:0]  ch;
         take = 0;
         chv  = 0;
         bad  = 0;
         ch   = 0;
         if (kind == KIND_LOAD) begin
            mem[addr] = value;
            push_word(0, 0, 0, 0, 0, 0, 1);
            return;
         end
         if (halted) begin
            push_word(0, 0, 0, 0, 0, 0, 1);
            return;
         end
         here = pc;
         for (int i = 0; i < 4; i++)
            word[8*i +: 8] = mem[16'(here + i)];
         op  = word[31:26];
         r1  = word[25:21];
         r2  = word[20:16];
         r3  = word[15:11];
         imm = {{16{word[15]}}, word[15:0]};
         a   = regs[r1];
         b   = regs[r2];
         c   = regs[r3];
         pc  = here + 4;
         case (op)
            OP_HALT: begin
               halted = 1;
               for (int i = 0; i < MSIE_NUM_REGS; i++)
                  push_word(0, 0, 0, 1, 5'(i), regs[i], i == MSIE_NUM_REGS - 1);
               return;
            end
            OP_ADD:  regs[r1] = b + c;
            OP_ADDI: regs[r1] = b + imm;
            OP_SUB:  regs[r1] = b - c;
            OP_SUBI: regs[r1] = b - imm;
            OP_MUL:  regs[r1] = b * c;
            OP_MULI: regs[r1] = b * imm;
            OP_LB:   regs[r1] = {24'd0, mem[16'(b + imm)]};
            OP_SB:   mem[16'(b + imm)] = a[7:0];
            OP_BEQ:  take = (a == b);
            OP_BNE:  take = (a != b);
            OP_BLT:  take = $signed(a) < $signed(b);
            OP_BGT:  take = $signed(b) < $signed(a);
            OP_BLE:  take = !($signed(b) < $signed(a));
            OP_BGE:  take = !($signed(a) < $signed(b));
            OP_J:    pc = {16'd0, word[15:0]};
            OP_JR:   pc = a;
            OP_JAL: begin
               regs[MSIE_LINK_REG] = pc;
               pc = {16'd0, word[15:0]};
            end
            OP_OUT: begin
               chv = 1;
               ch  = a[7:0];
            end
            default: bad = 1;
         endcase
         if (take)
            pc = here + (imm << 2);
         push_word(chv, ch, bad, 0, 0, 0, 1);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         $display("rsp mismatch on %s: got %h, want %h at %0t", field, got, want, $realtime);
         errors++;
      endtask

      // compares one accepted response word with the oldest prediction
      task check_response(logic [RSP_DATA_BITS-1:0] d, logic last);
         core_result_type e;
         if (expected_words.size() == 0) begin
            report("unexpected word", d[31:0], 0);
            return;
         end
         e = expected_words.pop_front();
         if (d[31:0] !== e.pc_value)      report("pc_value", d[31:0], e.pc_value);
         if (d[32] !== e.halted)          report("halted", d[32], e.halted);
         if (d[33] !== e.char_valid)      report("char_valid", d[33], e.char_valid);
         if (d[41:34] !== e.char_value)   report("char_value", d[41:34], e.char_value);
         if (d[42] !== e.bad_opcode)      report("bad_opcode", d[42], e.bad_opcode);
         if (d[43] !== e.dump_valid)      report("dump_valid", d[43], e.dump_valid);
         if (d[48:44] !== e.dump_index)   report("dump_index", d[48:44], e.dump_index);
         if (d[80:49] !== e.dump_value)   report("dump_value", d[80:49], e.dump_value);
         if (d[87:81] !== 7'd0)           report("padding", d[87:81], 0);
         if (last !== e.last)             report("tlast", last, e.last);
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [23:0]              req_tdata;   // load_address [15:0], load_byte [23:16]
   logic                     req_tuser;   // kind
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // pc_value .. dump_value, see core ports
   logic                     rsp_tlast;

   core_scoreboard sb;
   bit             send_gaps;     // sender idles at random
   bit             recv_gaps;     // receiver stalls at random
   bit             long_hold;     // one long receiver stall requested
   int             idle_cycles;

   localparam int WATCHDOG_LIMIT = 400000;   // covers the memory clearing pass
   localparam int LONG_HOLD      = 300;

   mips_subset_instruction_executor_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   // response monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tlast);
   end

   // watchdog: cycles without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold = 0;
            rsp_tready <= 0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // offers one request word from a falling edge and returns at the falling
   // edge after it was taken, valid still high
   task send_word(bit kind, bit [15:0] addr, bit [7:0] value);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {value, addr};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, addr, value);
      @(negedge clock);
   endtask

   function automatic bit [31:0] encode(bit [5:0] op, bit [4:0] r1, bit [4:0] r2,
                                        bit [15:0] imm);
      return {op, r1, r2, imm};
   endfunction

   // writes an instruction at the shadow pc, then steps it
   task run_instruction(bit [31:0] word);
      for (int i = 0; i < 4; i++)
         send_word(KIND_LOAD, 16'(sb.pc + i), word[8*i +: 8]);
      send_word(KIND_STEP, 16'($urandom), 8'($urandom));
   endtask

   function automatic bit [31:0] random_instruction(bit [5:0] op);
      bit [15:0] imm;
      imm = 16'($urandom);
      case ($urandom_range(0, 3))
         0: imm = 16'h7fff;
         1: imm = 16'h8000;
         default: ;
      endcase
      return encode(op, 5'($urandom), 5'($urandom), imm);
   endfunction

   initial begin
      bit [5:0] op;
      sb            = new();
      reset         = 1;
      req_tvalid    = 0;
      req_tuser     = 0;
      req_tdata     = 0;
      send_gaps     = 0;
      recv_gaps     = 0;
      long_hold     = 0;
      idle_cycles   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: address and byte extremes, operand extremes, wrapped fetch
      send_word(KIND_LOAD, 16'hffff, 8'hff);
      send_word(KIND_LOAD, 16'h0000, 8'h00);
      run_instruction(encode(OP_ADDI, 5'd1, 5'd0, 16'h7fff));
      run_instruction(encode(OP_ADDI, 5'd2, 5'd0, 16'h8000));
      run_instruction(encode(OP_MUL, 5'd3, 5'd1, {5'd1, 11'd0}));
      run_instruction(encode(OP_BLT, 5'd2, 5'd1, 16'd2));     // taken, signed
      run_instruction(encode(OP_BGT, 5'd2, 5'd1, 16'd2));     // falls through
      run_instruction(encode(OP_J, 5'd31, 5'd31, 16'hfffe));  // fetch straddles the wrap
      run_instruction(encode(6'd63, 5'd31, 5'd31, 16'hffff)); // bad opcode
      run_instruction(encode(OP_OUT, 5'd2, 5'd0, 16'd0));

      // every opcode but halt once with random operands
      send_gaps = 1;
      recv_gaps = 1;
      for (int n = 0; n < 18; n++) begin
         op = 6'(n + 1);
         if (n == 10)
            long_hold = 1;
         run_instruction(random_instruction(op));
      end

      // last part without idling: halt with its dump, then a halted core
      send_gaps = 0;
      recv_gaps = 0;
      run_instruction(encode(OP_HALT, 5'($urandom), 5'($urandom), 16'($urandom)));
      send_word(KIND_STEP, 16'($urandom), 8'($urandom));
      send_word(KIND_LOAD, 16'($urandom), 8'($urandom));
      send_word(KIND_STEP, 16'($urandom), 8'($urandom));
      req_tvalid <= 0;

      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
